[rtl/core/usc_pkg.sv]
// Shared types, codes and constants of the uplink session controller.
package usc_pkg;

    localparam int unsigned CFG_W      = 24;
    localparam int unsigned MS_W       = 32;
    localparam int unsigned SEC_W      = 32;
    localparam int unsigned SIZE_W     = 8;
    localparam int unsigned MSCNT_W    = 10;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [SIZE_W-1:0]  RECORD_BYTES = 8'd14;
    localparam logic [7:0]         SOF_BYTE     = 8'h55;
    localparam logic [7:0]         EOF_BYTE     = 8'hAA;
    localparam logic [7:0]         TYPE_ACK     = 8'h03;
    localparam logic [7:0]         TYPE_NACK    = 8'h04;
    localparam logic [MSCNT_W-1:0] MS_LAST      = 10'd999;

    localparam logic [CFG_W-1:0] KEEPALIVE_RST  = 24'd240000;
    localparam logic [CFG_W-1:0] ACK_TO_RST     = 24'd10000;
    localparam logic [CFG_W-1:0] RECONNECT_RST  = 24'd60000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECONNECT = 2'd2;

    typedef enum logic [1:0] {
        SS_CONNECT = 2'd0,
        SS_SEND    = 2'd1,
        SS_WAITACK = 2'd2,
        SS_BACKOFF = 2'd3
    } t_session;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_TYPE  = 2'd1,
        PH_CHECK = 2'd2,
        PH_END   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        PK_NONE = 2'd0,
        PK_ACK  = 2'd1,
        PK_NACK = 2'd2
    } t_pkind;

    typedef enum logic [1:0] {
        SK_IDENT = 2'd0,
        SK_KEEP  = 2'd1,
        SK_ALARM = 2'd2,
        SK_VAR   = 2'd3
    } t_sent_kind;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_CONNECT = 3'd1,
        ACT_IDENT   = 3'd2,
        ACT_ALARM   = 3'd3,
        ACT_VAR     = 3'd4,
        ACT_KEEP    = 3'd5,
        ACT_CLOSE   = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        RX_NONE = 2'd0,
        RX_ACK  = 2'd1,
        RX_NACK = 2'd2,
        RX_BAD  = 2'd3
    } t_rx;

    typedef struct packed {
        t_action           action;
        logic [SIZE_W-1:0] adv_alarm;
        logic [SIZE_W-1:0] adv_var;
        t_session          session;
        t_rx               rx_result;
        logic [SEC_W-1:0]  seconds;
    } t_result;

endpackage

[rtl/core/uplink_session_controller_unit.sv]
// Uplink session controller: tick/byte session machine, reply parser, output buffer.
// A result word is registered in the result register, or in the skid on a stall.
// Throughput: one word per cycle unless stalled; one update pass per accepted word.
// A two-entry output buffer (result register plus skid) keeps the input open while
// a result waits; the input stalls only when both entries are full.
// Reset (synchronous, active low) restores configuration defaults, the connect
// state, an idle parser, zeroed timers and an empty output buffer.
module uplink_session_controller_unit
    import usc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic                 i_link_up,
    input  logic                 i_connect_ok,
    input  logic                 i_write_ok,
    input  logic [SIZE_W-1:0]    i_alarm_size,
    input  logic [SIZE_W-1:0]    i_var_size,
    input  logic [7:0]           i_rx_byte,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_action,
    output logic [SIZE_W-1:0]    o_advance_alarm,
    output logic [SIZE_W-1:0]    o_advance_var,
    output logic [1:0]           o_session_state,
    output logic [1:0]           o_rx_result,
    output logic [SEC_W-1:0]     o_seconds,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]   r_keepalive_ms, r_ack_to_ms, r_reconnect_ms;

    t_session           r_session, n_session;
    t_phase             r_phase, n_phase;
    t_pkind             r_pkind, n_pkind;
    logic [MS_W-1:0]    r_now_ms, n_now_ms;
    logic [MS_W-1:0]    r_ack_start, n_ack_start;
    logic [MS_W-1:0]    r_backoff_start, n_backoff_start;
    logic [MS_W-1:0]    r_last_send, n_last_send;
    t_sent_kind         r_sent_kind, n_sent_kind;
    logic [SIZE_W-1:0]  r_sent_size, n_sent_size;
    logic [MSCNT_W-1:0] r_ms_in_sec, n_ms_in_sec;
    logic [SEC_W-1:0]   r_sec_count, n_sec_count;

    t_result            r_out_data, r_skid_data, n_result;
    logic               r_out_valid, r_skid_valid;

    logic               in_accept, out_fire;
    logic [MS_W-1:0]    now_inc;
    logic [MS_W-1:0]    ack_el_byte, ack_el_tick, keep_el, bo_el;
    logic [SIZE_W-1:0]  pick_size;
    logic               pick_alarm;
    logic [7:0]         want_check;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_fire    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;

    assign now_inc     = r_now_ms + 32'd1;
    assign ack_el_byte = r_now_ms - r_ack_start;
    assign ack_el_tick = now_inc - r_ack_start;
    assign keep_el     = now_inc - r_last_send;
    assign bo_el       = now_inc - r_backoff_start;

    // alarm queue has priority even when its record is unusable
    assign pick_alarm  = (i_alarm_size != '0);
    assign pick_size   = pick_alarm ? i_alarm_size : i_var_size;
    assign want_check  = (r_pkind == PK_ACK) ? TYPE_ACK : TYPE_NACK;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keepalive_ms <= KEEPALIVE_RST;
            r_ack_to_ms    <= ACK_TO_RST;
            r_reconnect_ms <= RECONNECT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEEPALIVE: r_keepalive_ms <= i_cfg_data;
                CFG_ACK_TO:    r_ack_to_ms    <= i_cfg_data;
                CFG_RECONNECT: r_reconnect_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state and result for the word at the input
    always_comb begin
        n_session       = r_session;
        n_phase         = r_phase;
        n_pkind         = r_pkind;
        n_now_ms        = r_now_ms;
        n_ack_start     = r_ack_start;
        n_backoff_start = r_backoff_start;
        n_last_send     = r_last_send;
        n_sent_kind     = r_sent_kind;
        n_sent_size     = r_sent_size;
        n_ms_in_sec     = r_ms_in_sec;
        n_sec_count     = r_sec_count;
        n_result        = '{action: ACT_NONE, adv_alarm: '0, adv_var: '0,
                            session: r_session, rx_result: RX_NONE, seconds: '0};

        if (i_cmd) begin
            unique case (r_phase)
                PH_START: begin
                    if (i_rx_byte == SOF_BYTE) n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    if (i_rx_byte == TYPE_ACK) begin
                        n_pkind = PK_ACK;
                        n_phase = PH_CHECK;
                    end else if (i_rx_byte == TYPE_NACK) begin
                        n_pkind = PK_NACK;
                        n_phase = PH_CHECK;
                    end else begin
                        n_pkind = PK_NONE;
                        n_phase = PH_START;
                    end
                end
                PH_CHECK: begin
                    if (r_pkind != PK_NONE && i_rx_byte == want_check) begin
                        n_phase = PH_END;
                    end else begin
                        n_phase            = PH_START;
                        n_pkind            = PK_NONE;
                        n_result.rx_result = RX_BAD;
                    end
                end
                PH_END: begin
                    if (i_rx_byte == EOF_BYTE && r_pkind == PK_ACK) begin
                        n_result.rx_result = RX_ACK;
                    end else if (i_rx_byte == EOF_BYTE && r_pkind == PK_NACK) begin
                        n_result.rx_result = RX_NACK;
                    end else begin
                        n_result.rx_result = RX_BAD;
                    end
                    n_phase = PH_START;
                    n_pkind = PK_NONE;
                end
                default: ;
            endcase

            // a reply counts only while waiting and before the timeout
            if (r_session == SS_WAITACK && ack_el_byte < {8'd0, r_ack_to_ms}) begin
                if (n_result.rx_result == RX_ACK) begin
                    if (r_sent_kind == SK_ALARM) n_result.adv_alarm = r_sent_size;
                    else if (r_sent_kind == SK_VAR) n_result.adv_var = r_sent_size;
                    n_session = SS_SEND;
                end else if (n_result.rx_result == RX_NACK) begin
                    n_session = SS_SEND;
                end
            end
        end else begin
            n_now_ms = now_inc;
            if (r_ms_in_sec == MS_LAST) begin
                n_ms_in_sec = '0;
                n_sec_count = r_sec_count + 32'd1;
            end else begin
                n_ms_in_sec = r_ms_in_sec + 10'd1;
            end

            unique case (r_session)
                SS_CONNECT: begin
                    if (i_link_up) begin
                        if (i_write_ok) begin
                            n_result.action = ACT_IDENT;
                            n_ack_start     = now_inc;
                            n_last_send     = now_inc;
                            n_sent_kind     = SK_IDENT;
                            n_session       = SS_WAITACK;
                        end
                    end else if (i_connect_ok) begin
                        n_result.action = ACT_CONNECT;
                    end else begin
                        n_result.action = ACT_CLOSE;
                        n_session       = SS_BACKOFF;
                        n_backoff_start = now_inc;
                    end
                end
                SS_SEND: begin
                    if (!i_link_up) begin
                        n_session = SS_CONNECT;
                    end else if (pick_size != '0) begin
                        if (pick_size == RECORD_BYTES && i_write_ok) begin
                            n_result.action = pick_alarm ? ACT_ALARM : ACT_VAR;
                            n_session       = SS_WAITACK;
                            n_ack_start     = now_inc;
                            n_last_send     = now_inc;
                            n_sent_size     = pick_size;
                            n_sent_kind     = pick_alarm ? SK_ALARM : SK_VAR;
                        end
                    end else if (keep_el >= {8'd0, r_keepalive_ms}) begin
                        if (i_write_ok) begin
                            n_result.action = ACT_KEEP;
                            n_session       = SS_WAITACK;
                            n_ack_start     = now_inc;
                            n_last_send     = now_inc;
                            n_sent_kind     = SK_KEEP;
                        end else begin
                            // failed keep-alive: back off
                            n_session       = SS_BACKOFF;
                            n_backoff_start = now_inc;
                        end
                    end
                end
                SS_WAITACK: begin
                    if (!i_link_up) begin
                        n_session       = SS_BACKOFF;
                        n_backoff_start = now_inc;
                    end else if (ack_el_tick >= {8'd0, r_ack_to_ms}) begin
                        n_session = SS_SEND;
                    end
                end
                SS_BACKOFF: begin
                    if (bo_el > {8'd0, r_reconnect_ms}) n_session = SS_CONNECT;
                end
                default: ;
            endcase
        end

        n_result.session = n_session;
        n_result.seconds = n_sec_count;
    end

    // session and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session       <= SS_CONNECT;
            r_phase         <= PH_START;
            r_pkind         <= PK_NONE;
            r_now_ms        <= '0;
            r_ack_start     <= '0;
            r_backoff_start <= '0;
            r_last_send     <= '0;
            r_sent_kind     <= SK_IDENT;
            r_sent_size     <= '0;
            r_ms_in_sec     <= '0;
            r_sec_count     <= '0;
        end else if (in_accept) begin
            r_session       <= n_session;
            r_phase         <= n_phase;
            r_pkind         <= n_pkind;
            r_now_ms        <= n_now_ms;
            r_ack_start     <= n_ack_start;
            r_backoff_start <= n_backoff_start;
            r_last_send     <= n_last_send;
            r_sent_kind     <= n_sent_kind;
            r_sent_size     <= n_sent_size;
            r_ms_in_sec     <= n_ms_in_sec;
            r_sec_count     <= n_sec_count;
        end
    end

    // output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            // refill the result register, skid first
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output buffer payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out_data <= r_skid_valid ? r_skid_data : n_result;
        end else if (in_accept) begin
            r_skid_data <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_action        = r_out_data.action;
    assign o_advance_alarm = r_out_data.adv_alarm;
    assign o_advance_var   = r_out_data.adv_var;
    assign o_session_state = r_out_data.session;
    assign o_rx_result     = r_out_data.rx_result;
    assign o_seconds       = r_out_data.seconds;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result word");

    a_ms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ms_in_sec <= MS_LAST)
        else $error("millisecond count out of range");

    a_parse_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CHECK || r_phase == PH_END) |-> (r_pkind != PK_NONE))
        else $error("parser past type byte without a frame kind");

    a_adv_on_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.adv_alarm != '0 || r_out_data.adv_var != '0))
        |-> (r_out_data.rx_result == RX_ACK && r_out_data.session == SS_SEND))
        else $error("queue advance without an accepted ACK");

    a_adv_one_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.adv_alarm == '0 || r_out_data.adv_var == '0))
        else $error("both queues advanced by one word");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result word changed");

endmodule

[test/uplink_session_controller_unit_test.sv]
// Self-checking testbench for the uplink session controller: directed and random sessions.
module uplink_session_controller_unit_test;
    import usc_pkg::*;

    typedef struct packed {
        logic              cmd;
        logic              link_up;
        logic              connect_ok;
        logic              write_ok;
        logic [SIZE_W-1:0] alarm_size;
        logic [SIZE_W-1:0] var_size;
        logic [7:0]        rx_byte;
    } t_usc_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_cmd;
    logic                 i_link_up;
    logic                 i_connect_ok;
    logic                 i_write_ok;
    logic [SIZE_W-1:0]    i_alarm_size;
    logic [SIZE_W-1:0]    i_var_size;
    logic [7:0]           i_rx_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [2:0]           o_action;
    logic [SIZE_W-1:0]    o_advance_alarm;
    logic [SIZE_W-1:0]    o_advance_var;
    logic [1:0]           o_session_state;
    logic [1:0]           o_rx_result;
    logic [SEC_W-1:0]     o_seconds;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    uplink_session_controller_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_link_up       (i_link_up),
        .i_connect_ok    (i_connect_ok),
        .i_write_ok      (i_write_ok),
        .i_alarm_size    (i_alarm_size),
        .i_var_size      (i_var_size),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_action        (o_action),
        .o_advance_alarm (o_advance_alarm),
        .o_advance_var   (o_advance_var),
        .o_session_state (o_session_state),
        .o_rx_result     (o_rx_result),
        .o_seconds       (o_seconds),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // predicted controller state, mirrors the block after each accepted word
    t_session         sess      = SS_CONNECT;
    t_phase           phase     = PH_START;
    t_pkind           pkind     = PK_NONE;
    logic [MS_W-1:0]  ms_now    = '0;
    logic [MS_W-1:0]  ack_t0    = '0;
    logic [MS_W-1:0]  boff_t0   = '0;
    logic [MS_W-1:0]  send_t0   = '0;
    t_sent_kind       sent_kind = SK_IDENT;
    logic [SIZE_W-1:0] sent_size = '0;
    logic [MSCNT_W-1:0] ms_frac = '0;
    logic [SEC_W-1:0] secs      = '0;
    logic [CFG_W-1:0] keepalive_cfg = KEEPALIVE_RST;
    logic [CFG_W-1:0] ack_to_cfg    = ACK_TO_RST;
    logic [CFG_W-1:0] reconnect_cfg = RECONNECT_RST;

    t_result results_due[$];
    int      mismatch_count  = 0;
    int      hold_off_cycles = 0;
    bit      tx_steady       = 1'b0;
    bit      rx_steady       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_result next_session_result(input t_usc_word w);
        t_result           r;
        logic [SIZE_W-1:0] sz;
        t_sent_kind        kind;
        r = '0;
        if (w.cmd) begin
            case (phase)
                PH_START: begin
                    if (w.rx_byte == SOF_BYTE) phase = PH_TYPE;
                end
                PH_TYPE: begin
                    if (w.rx_byte == TYPE_ACK) begin
                        pkind = PK_ACK;
                        phase = PH_CHECK;
                    end else if (w.rx_byte == TYPE_NACK) begin
                        pkind = PK_NACK;
                        phase = PH_CHECK;
                    end else begin
                        pkind = PK_NONE;
                        phase = PH_START;
                    end
                end
                PH_CHECK: begin
                    if (pkind != PK_NONE &&
                        w.rx_byte == ((pkind == PK_ACK) ? TYPE_ACK : TYPE_NACK)) begin
                        phase = PH_END;
                    end else begin
                        phase = PH_START;
                        pkind = PK_NONE;
                        r.rx_result = RX_BAD;
                    end
                end
                default: begin
                    if (w.rx_byte == EOF_BYTE && pkind != PK_NONE)
                        r.rx_result = (pkind == PK_ACK) ? RX_ACK : RX_NACK;
                    else
                        r.rx_result = RX_BAD;
                    phase = PH_START;
                    pkind = PK_NONE;
                end
            endcase
            // replies count only while waiting and before the ack timeout
            if (sess == SS_WAITACK && ms_now - ack_t0 < 32'(ack_to_cfg)) begin
                if (r.rx_result == RX_ACK) begin
                    if (sent_kind == SK_ALARM) r.adv_alarm = sent_size;
                    else if (sent_kind == SK_VAR) r.adv_var = sent_size;
                    sess = SS_SEND;
                end else if (r.rx_result == RX_NACK) begin
                    sess = SS_SEND;
                end
            end
        end else begin
            ms_now = ms_now + 32'd1;
            if (ms_frac == MS_LAST) begin
                ms_frac = '0;
                secs = secs + 32'd1;
            end else begin
                ms_frac = ms_frac + 10'd1;
            end
            case (sess)
                SS_CONNECT: begin
                    if (w.link_up) begin
                        if (w.write_ok) begin
                            r.action  = ACT_IDENT;
                            ack_t0    = ms_now;
                            send_t0   = ms_now;
                            sent_kind = SK_IDENT;
                            sess      = SS_WAITACK;
                        end
                    end else if (w.connect_ok) begin
                        r.action = ACT_CONNECT;
                    end else begin
                        r.action = ACT_CLOSE;
                        sess     = SS_BACKOFF;
                        boff_t0  = ms_now;
                    end
                end
                SS_SEND: begin
                    if (!w.link_up) begin
                        sess = SS_CONNECT;
                    end else begin
                        // alarm queue first, even when its record is malformed
                        sz   = w.alarm_size;
                        kind = SK_ALARM;
                        if (sz == 0) begin
                            sz   = w.var_size;
                            kind = SK_VAR;
                        end
                        if (sz != 0) begin
                            if (sz == RECORD_BYTES && w.write_ok) begin
                                r.action  = (kind == SK_ALARM) ? ACT_ALARM : ACT_VAR;
                                sess      = SS_WAITACK;
                                ack_t0    = ms_now;
                                send_t0   = ms_now;
                                sent_size = sz;
                                sent_kind = kind;
                            end
                        end else if (ms_now - send_t0 >= 32'(keepalive_cfg)) begin
                            if (w.write_ok) begin
                                r.action  = ACT_KEEP;
                                sess      = SS_WAITACK;
                                ack_t0    = ms_now;
                                send_t0   = ms_now;
                                sent_kind = SK_KEEP;
                            end else begin
                                sess    = SS_BACKOFF;
                                boff_t0 = ms_now;
                            end
                        end
                    end
                end
                SS_WAITACK: begin
                    if (!w.link_up) begin
                        sess    = SS_BACKOFF;
                        boff_t0 = ms_now;
                    end else if (ms_now - ack_t0 >= 32'(ack_to_cfg)) begin
                        sess = SS_SEND;
                    end
                end
                default: begin
                    if (ms_now - boff_t0 > 32'(reconnect_cfg)) sess = SS_CONNECT;
                end
            endcase
        end
        r.session = sess;
        r.seconds = secs;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: result word with none outstanding, expected nothing, got action %0d",
                         $time, o_action);
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                check_field("action", want.action, o_action);
                check_field("advance_alarm", want.adv_alarm, o_advance_alarm);
                check_field("advance_var", want.adv_var, o_advance_var);
                check_field("session_state", want.session, o_session_state);
                check_field("rx_result", want.rx_result, o_rx_result);
                check_field("seconds", want.seconds, o_seconds);
            end
        end
    end

    // result side: random stall per word, plus an optional long hold-off
    initial begin
        int stall_len;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall_len = rx_steady ? 0 : $urandom_range(0, 17);
            if (hold_off_cycles > 0) begin
                stall_len += hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_word(input t_usc_word w);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= w.cmd;
        i_link_up    <= w.link_up;
        i_connect_ok <= w.connect_ok;
        i_write_ok   <= w.write_ok;
        i_alarm_size <= w.alarm_size;
        i_var_size   <= w.var_size;
        i_rx_byte    <= w.rx_byte;
        do @(posedge i_clk); while (o_in_stall);
        results_due.push_back(next_session_result(w));
    endtask

    task automatic send_tick(input logic link, conn, wr, input logic [SIZE_W-1:0] asz, vsz);
        send_word('{cmd: 1'b0, link_up: link, connect_ok: conn, write_ok: wr,
                    alarm_size: asz, var_size: vsz, rx_byte: 8'($urandom_range(0, 255))});
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word('{cmd: 1'b1, link_up: 1'($urandom), connect_ok: 1'($urandom),
                    write_ok: 1'($urandom), alarm_size: 8'($urandom_range(0, 255)),
                    var_size: 8'($urandom_range(0, 255)), rx_byte: b});
    endtask

    task automatic send_frame(input logic [7:0] kind_b, check_b, end_b);
        send_byte(SOF_BYTE);
        send_byte(kind_b);
        send_byte(check_b);
        send_byte(end_b);
    endtask

    // hold the input idle until every result is back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] keepalive, ack_to, reconnect);
        logic [CFG_W-1:0]     vals[3];
        logic [CFG_IDX_W-1:0] idx[3];
        drain();
        vals = '{keepalive, ack_to, reconnect};
        idx  = '{CFG_KEEPALIVE, CFG_ACK_TO, CFG_RECONNECT};
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid   <= 1'b0;
        keepalive_cfg = keepalive;
        ack_to_cfg    = ack_to;
        reconnect_cfg = reconnect;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return RECORD_BYTES;
        if (r < 75) return '0;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_reply();
        int         r;
        logic [7:0] kind_b;
        r = $urandom_range(0, 99);
        kind_b = (r < 70) ? TYPE_ACK : TYPE_NACK;
        if (r < 88) send_frame(kind_b, kind_b, EOF_BYTE);
        else if (r < 92) send_frame(8'($urandom_range(0, 255)), kind_b, EOF_BYTE);
        else if (r < 96) send_frame(kind_b, 8'($urandom_range(0, 255)), EOF_BYTE);
        else send_frame(kind_b, kind_b, 8'($urandom_range(0, 255)));
    endtask

    // mostly healthy link traffic; replies follow sends, with stray bytes mixed in
    task automatic run_sessions(input int n);
        int sent;
        int pick;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_byte(8'($urandom_range(0, 255)));
                sent += 1;
            end else if (pick < 12 || (sess == SS_WAITACK && pick < 55)) begin
                send_reply();
                sent += 4;
            end else begin
                send_tick($urandom_range(0, 99) < 93, 1'($urandom),
                          $urandom_range(0, 99) < 85, pick_size(), pick_size());
                sent += 1;
            end
        end
    endtask

    task automatic test_reset_defaults();
        run_sessions(40);
    endtask

    task automatic test_directed();
        set_regs(24'd1, 24'd2, 24'd1);
        // resync the parser and walk back to the connect state
        send_byte(8'h00);
        while (sess != SS_CONNECT) send_tick(1'b0, 1'b0, 1'b1, 8'd0, 8'd0);
        send_tick(1'b0, 1'b0, 1'b0, 8'd255, 8'd255);
        send_word('{cmd: 1'b1, link_up: 1'b1, connect_ok: 1'b1, write_ok: 1'b1,
                    alarm_size: 8'd255, var_size: 8'd255, rx_byte: SOF_BYTE});
        send_tick(1'b0, 1'b1, 1'b1, 8'd0, 8'd0);
        send_tick(1'b0, 1'b1, 1'b1, 8'd0, 8'd0);
        send_tick(1'b0, 1'b1, 1'b0, 8'd0, 8'd0);
        send_tick(1'b1, 1'b0, 1'b0, 8'd0, 8'd0);
        send_tick(1'b1, 1'b0, 1'b1, 8'd0, 8'd0);
        send_byte(TYPE_ACK);
        send_byte(TYPE_ACK);
        send_byte(EOF_BYTE);
        send_tick(1'b1, 1'b0, 1'b1, 8'd13, RECORD_BYTES);
        send_tick(1'b1, 1'b0, 1'b1, 8'd0, RECORD_BYTES);
        send_frame(TYPE_ACK, TYPE_ACK, EOF_BYTE);
        send_tick(1'b1, 1'b0, 1'b1, RECORD_BYTES, 8'd0);
        send_frame(TYPE_NACK, TYPE_NACK, EOF_BYTE);
        send_tick(1'b1, 1'b0, 1'b0, 8'd0, 8'd0);
        send_byte(SOF_BYTE);
        send_byte(8'h07);
        send_byte(SOF_BYTE);
        send_byte(TYPE_ACK);
        send_byte(TYPE_NACK);
        send_frame(TYPE_ACK, TYPE_ACK, EOF_BYTE);
        send_frame(TYPE_NACK, TYPE_NACK, 8'hFF);
    endtask

    task automatic test_extreme_timeouts();
        set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        run_sessions(120);
        set_regs(24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom_range(1, 24'hFFFFFF)),
                 24'($urandom_range(1, 24'hFFFFFF)));
        run_sessions(60);
    endtask

    task automatic test_random_sessions();
        set_regs(24'd1, 24'd1, 24'd1);
        run_sessions(220);
        repeat (4) begin
            set_regs(24'($urandom_range(1, 40)), 24'($urandom_range(2, 40)),
                     24'($urandom_range(1, 40)));
            run_sessions(220);
        end
    endtask

    task automatic test_backpressure();
        set_regs(24'd6, 24'd12, 24'd5);
        hold_off_cycles = 300;
        tx_steady = 1'b1;
        run_sessions(60);
        tx_steady = 1'b0;
        drain();
        run_sessions(100);
    endtask

    task automatic test_steady_stream();
        set_regs(24'd3, 24'd8, 24'd4);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_sessions(200);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        run_sessions(40);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_cmd        <= 1'b0;
        i_link_up    <= 1'b0;
        i_connect_ok <= 1'b0;
        i_write_ok   <= 1'b0;
        i_alarm_size <= '0;
        i_var_size   <= '0;
        i_rx_byte    <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_KEEPALIVE;
        i_cfg_data   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_extreme_timeouts();
        test_random_sessions();
        test_backpressure();
        test_steady_stream();
        drain();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
